// ===== src/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion unit.
package rmq_pkg;

	localparam int ELEM_W = 16;
	localparam int SUM_W  = 19;
	localparam int NUM_W  = 17;
	localparam int MAG_W  = 17;
	localparam int QDEPTH = 4;

	localparam logic signed [ELEM_W-1:0] QMAX = 16'sh7fff;
	localparam logic signed [ELEM_W-1:0] QMIN = 16'sh8000;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	// Numerators are ordered by output slot, skipping the diagonal one:
	// trace (x,y,z), x (w,y,z), y (w,x,z), z (w,x,y).
	typedef struct packed {
		branch_t                  br;
		logic signed [SUM_W-1:0]  sum;
		logic signed [NUM_W-1:0]  num0;
		logic signed [NUM_W-1:0]  num1;
		logic signed [NUM_W-1:0]  num2;
	} item_t;

	typedef struct packed {
		logic                     valid;
		item_t                    item;
	} push_t;

endpackage

// ===== src/rmq_front.sv =====
// Front end: takes a matrix, picks the branch and forms radicand sum and numerators.
module rmq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic signed [15:0]  m00,
	input  logic signed [15:0]  m01,
	input  logic signed [15:0]  m02,
	input  logic signed [15:0]  m10,
	input  logic signed [15:0]  m11,
	input  logic signed [15:0]  m12,
	input  logic signed [15:0]  m20,
	input  logic signed [15:0]  m21,
	input  logic signed [15:0]  m22,
	output rmq_pkg::push_t      push
);
	import rmq_pkg::*;

	logic signed [SUM_W-1:0] trace;
	logic signed [NUM_W-1:0] d_x, d_y, d_z, s_xy, s_xz, s_yz;
	item_t                   item;
	logic                    valid_s1;
	item_t                   item_s1;

	always_comb begin
		trace = SUM_W'(m00) + SUM_W'(m11) + SUM_W'(m22);
		d_x   = NUM_W'(m21) - NUM_W'(m12);
		d_y   = NUM_W'(m02) - NUM_W'(m20);
		d_z   = NUM_W'(m10) - NUM_W'(m01);
		s_xy  = NUM_W'(m01) + NUM_W'(m10);
		s_xz  = NUM_W'(m02) + NUM_W'(m20);
		s_yz  = NUM_W'(m12) + NUM_W'(m21);
		if (trace > 0) begin
			item.br   = BR_TRACE;
			item.sum  = trace;
			item.num0 = d_x;
			item.num1 = d_y;
			item.num2 = d_z;
		end else if (m00 > m11 && m00 > m22) begin
			item.br   = BR_X;
			item.sum  = SUM_W'(m00) - SUM_W'(m11) - SUM_W'(m22);
			item.num0 = d_x;
			item.num1 = s_xy;
			item.num2 = s_xz;
		end else if (m11 > m22) begin
			item.br   = BR_Y;
			item.sum  = SUM_W'(m11) - SUM_W'(m00) - SUM_W'(m22);
			item.num0 = d_y;
			item.num1 = s_xy;
			item.num2 = s_yz;
		end else begin
			item.br   = BR_Z;
			item.sum  = SUM_W'(m22) - SUM_W'(m00) - SUM_W'(m11);
			item.num0 = d_z;
			item.num1 = s_xz;
			item.num2 = s_yz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	assign push.valid = valid_s1;
	assign push.item  = item_s1;

endmodule

// ===== src/rmq_fifo.sv =====
// Short queue between front end and back end.
module rmq_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  rmq_pkg::push_t      push,
	output logic                pop,
	output rmq_pkg::item_t      head,
	output logic [$clog2(rmq_pkg::QDEPTH+1)-1:0] count,
	output logic                almost_full
);
	import rmq_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH+1);

	item_t          mem_q [QDEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  cnt_q;

	assign pop         = (cnt_q != '0);
	assign head        = mem_q[rd_q];
	assign count       = cnt_q;
	assign almost_full = (cnt_q >= CW'(QDEPTH-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CW'(push.valid) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.item;
		end
	end

endmodule

// ===== src/rmq_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt #(
	parameter int RW = 24,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   rad,
	input  logic [SW-1:0]     side_in,
	output logic              out_valid,
	output logic [RW-1:0]     root,
	output logic [SW-1:0]     side_out
);
	localparam int RADW = 2 * RW;

	logic [RW-1:0]   vld_s;
	logic [RW:0]     rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [RADW-1:0] rad_s  [RW];
	logic [SW-1:0]   side_s [RW];

	for (genvar g = 0; g < RW; g++) begin : g_stg
		logic            v_i;
		logic [RW:0]     rem_i;
		logic [RW-1:0]   root_i;
		logic [RADW-1:0] rad_i;
		logic [SW-1:0]   side_i;
		logic [RW+2:0]   remx, trial, rem_n;
		logic            ge;

		if (g == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = vld_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign root_i = root_s[g-1];
			assign rad_i  = rad_s[g-1];
			assign side_i = side_s[g-1];
		end

		assign remx  = {rem_i, rad_i[RADW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};
		assign ge    = (remx >= trial);
		assign rem_n = ge ? (remx - trial) : remx;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= rem_n[RW:0];
			root_s[g] <= {root_i[RW-2:0], ge};
			rad_s[g]  <= {rad_i[RADW-3:0], 2'b00};
			side_s[g] <= side_i;
		end
	end

	assign out_valid = vld_s[RW-1];
	assign root      = root_s[RW-1];
	assign side_out  = side_s[RW-1];

endmodule

// ===== src/rmq_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
module rmq_div #(
	parameter int DW    = 25,
	parameter int NW    = 31,
	parameter int LANES = 3,
	parameter int SW    = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [DW-1:0]              den,
	input  logic [LANES-1:0][NW-1:0]   dvd,
	input  logic [SW-1:0]              side_in,
	output logic                       out_valid,
	output logic [LANES-1:0][NW-1:0]   quo,
	output logic [SW-1:0]              side_out
);
	logic [NW-1:0]             vld_s;
	logic [DW-1:0]             den_s  [NW];
	logic [LANES-1:0][DW-1:0]  rem_s  [NW];
	logic [LANES-1:0][NW-1:0]  dvd_s  [NW];
	logic [LANES-1:0][NW-1:0]  quo_s  [NW];
	logic [SW-1:0]             side_s [NW];

	for (genvar g = 0; g < NW; g++) begin : g_stg
		logic                      v_i;
		logic [DW-1:0]             den_i;
		logic [LANES-1:0][DW-1:0]  rem_i;
		logic [LANES-1:0][NW-1:0]  dvd_i, quo_i;
		logic [SW-1:0]             side_i;

		if (g == 0) begin : g_first
			assign v_i    = in_valid;
			assign den_i  = den;
			assign rem_i  = '0;
			assign dvd_i  = dvd;
			assign quo_i  = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = vld_s[g-1];
			assign den_i  = den_s[g-1];
			assign rem_i  = rem_s[g-1];
			assign dvd_i  = dvd_s[g-1];
			assign quo_i  = quo_s[g-1];
			assign side_i = side_s[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			den_s[g]  <= den_i;
			side_s[g] <= side_i;
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] remx, diff;
			logic        ge;

			assign remx = {rem_i[l], dvd_i[l][NW-1]};
			assign ge   = (remx >= {1'b0, den_i});
			assign diff = remx - {1'b0, den_i};

			always_ff @(posedge clk) begin
				rem_s[g][l] <= ge ? diff[DW-1:0] : remx[DW-1:0];
				dvd_s[g][l] <= {dvd_i[l][NW-2:0], 1'b0};
				quo_s[g][l] <= {quo_i[l][NW-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign quo       = quo_s[NW-1];
	assign side_out  = side_s[NW-1];

endmodule

// ===== src/rmq_back.sv =====
// Back end: square root, three divisions, saturation and output ordering.
module rmq_back #(
	parameter int FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rmq_pkg::item_t      item,
	output logic                done,
	output logic signed [15:0]  qx,
	output logic signed [15:0]  qy,
	output logic signed [15:0]  qz,
	output logic signed [15:0]  qw,
	output logic [1:0]          branch_taken,
	output logic                saturated
);
	import rmq_pkg::*;

	localparam int VW   = FRAC_BITS + 20;
	localparam int RW   = FRAC_BITS + 10;
	localparam int DW   = RW + 1;
	localparam int NW   = MAG_W + FRAC_BITS;
	localparam int SW1  = 2 + 3 * NUM_W;
	localparam int SW2  = 2 + 3 + 1 + ELEM_W;

	logic signed [VW-1:0] v;
	logic [2*RW-1:0]      rad;
	logic                 sq_valid;
	logic [RW-1:0]        root;
	logic [SW1-1:0]       sq_side;
	branch_t              sq_br;
	logic signed [NUM_W-1:0] n0, n1, n2;
	logic [2:0]           sgn;
	logic [2:0][NW-1:0]   dvd;
	logic [MAG_W-1:0]     mag0, mag1, mag2;
	logic [ELEM_W-1:0]    diag;
	logic                 diag_sat;
	logic                 dv_valid;
	logic [2:0][NW-1:0]   quo;
	logic [SW2-1:0]       dv_side;
	branch_t              f_br;
	logic [2:0]           f_sgn;
	logic                 f_dsat;
	logic [ELEM_W-1:0]    f_diag;
	logic [2:0][ELEM_W-1:0] res;
	logic [2:0]           rsat;
	logic [ELEM_W-1:0]    ox, oy, oz, ow;

	logic                 done_q;
	logic [ELEM_W-1:0]    qx_q, qy_q, qz_q, qw_q;
	logic [1:0]           br_q;
	logic                 sat_q;

	always_comb begin
		v   = VW'(item.sum) + (VW'(1) << FRAC_BITS);
		rad = (!v[VW-1] && (v != '0)) ? {v, {FRAC_BITS{1'b0}}} : '0;
	end

	rmq_sqrt #(.RW(RW), .SW(SW1)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.rad      (rad),
		.side_in  ({item.br, item.num0, item.num1, item.num2}),
		.out_valid(sq_valid),
		.root     (root),
		.side_out (sq_side)
	);

	always_comb begin
		sq_br    = branch_t'(sq_side[SW1-1 -: 2]);
		n0       = sq_side[3*NUM_W-1 -: NUM_W];
		n1       = sq_side[2*NUM_W-1 -: NUM_W];
		n2       = sq_side[NUM_W-1:0];
		sgn      = {n0[NUM_W-1], n1[NUM_W-1], n2[NUM_W-1]};
		mag0     = n0[NUM_W-1] ? MAG_W'(-n0) : MAG_W'(n0);
		mag1     = n1[NUM_W-1] ? MAG_W'(-n1) : MAG_W'(n1);
		mag2     = n2[NUM_W-1] ? MAG_W'(-n2) : MAG_W'(n2);
		dvd[0]   = {mag0, {FRAC_BITS{1'b0}}};
		dvd[1]   = {mag1, {FRAC_BITS{1'b0}}};
		dvd[2]   = {mag2, {FRAC_BITS{1'b0}}};
		diag_sat = (root[RW-1:ELEM_W] != '0);
		diag     = diag_sat ? QMAX : root[ELEM_W:1];
	end

	rmq_div #(.DW(DW), .NW(NW), .LANES(3), .SW(SW2)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_valid),
		.den      ({root, 1'b0}),
		.dvd      (dvd),
		.side_in  ({sq_br, sgn, diag_sat, diag}),
		.out_valid(dv_valid),
		.quo      (quo),
		.side_out (dv_side)
	);

	always_comb begin
		f_br   = branch_t'(dv_side[SW2-1 -: 2]);
		f_sgn  = dv_side[SW2-3 -: 3];
		f_dsat = dv_side[ELEM_W];
		f_diag = dv_side[ELEM_W-1:0];
		for (int l = 0; l < 3; l++) begin
			if (f_sgn[2-l]) begin
				rsat[l] = (quo[l] > NW'(32768));
				res[l]  = rsat[l] ? QMIN : (~quo[l][ELEM_W-1:0] + 1'b1);
			end else begin
				rsat[l] = (quo[l] > NW'(32767));
				res[l]  = rsat[l] ? QMAX : quo[l][ELEM_W-1:0];
			end
		end
		unique case (f_br)
			BR_TRACE: begin
				ox = res[0]; oy = res[1]; oz = res[2]; ow = f_diag;
			end
			BR_X: begin
				ow = res[0]; ox = f_diag; oy = res[1]; oz = res[2];
			end
			BR_Y: begin
				ow = res[0]; ox = res[1]; oy = f_diag; oz = res[2];
			end
			default: begin
				ow = res[0]; ox = res[1]; oy = res[2]; oz = f_diag;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		qx_q  <= ox;
		qy_q  <= oy;
		qz_q  <= oz;
		qw_q  <= ow;
		br_q  <= f_br;
		sat_q <= f_dsat | (|rsat);
	end

	assign done         = done_q;
	assign qx           = qx_q;
	assign qy           = qy_q;
	assign qz           = qz_q;
	assign qw           = qw_q;
	assign branch_taken = br_q;
	assign saturated    = sat_q;

endmodule

// ===== src/rotation_matrix_to_quaternion_unit.sv =====
// Top level of the rotation matrix to quaternion unit.
//
// Usage: drive the nine Q2.14 matrix elements m00..m22 and raise start. A
// transaction is taken at a rising edge where start is high and busy is low.
// Each transaction gives one result: qx, qy, qz, qw, branch_taken and saturated
// are valid for exactly one cycle while done is high.
//
// Each transaction passes one front end stage, the queue, FRAC_BITS+10 square
// root stages, FRAC_BITS+17 divider stages and the output register. Throughput
// is one transaction per cycle while busy is low; the square root and the three
// divider lanes are fully pipelined, one result bit per stage.
//
// busy rises only when the four entry queue between front and back is nearly
// full; the back end drains it every cycle, so in practice it stays low.
// Results come in acceptance order. The receiver cannot stall: done is a
// one-cycle strobe. Reset clears all valid flags and the queue; no result
// appears until a transaction has been accepted.
module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  m00,
	input  logic signed [15:0]  m01,
	input  logic signed [15:0]  m02,
	input  logic signed [15:0]  m10,
	input  logic signed [15:0]  m11,
	input  logic signed [15:0]  m12,
	input  logic signed [15:0]  m20,
	input  logic signed [15:0]  m21,
	input  logic signed [15:0]  m22,
	output logic                done,
	output logic signed [15:0]  qx,
	output logic signed [15:0]  qy,
	output logic signed [15:0]  qz,
	output logic signed [15:0]  qw,
	output logic [1:0]          branch_taken,
	output logic                saturated
);
	import rmq_pkg::*;

	localparam int CW = $clog2(QDEPTH+1);

	push_t          push;
	logic           pop;
	item_t          head;
	logic [CW-1:0]  q_count;
	logic           q_almost_full;
	logic           accept;

	assign accept = start & ~busy;
	assign busy   = q_almost_full;

	rmq_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.m00   (m00),
		.m01   (m01),
		.m02   (m02),
		.m10   (m10),
		.m11   (m11),
		.m12   (m12),
		.m20   (m20),
		.m21   (m21),
		.m22   (m22),
		.push  (push)
	);

	rmq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.count      (q_count),
		.almost_full(q_almost_full)
	);

	rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pop),
		.item        (head),
		.done        (done),
		.qx          (qx),
		.qy          (qy),
		.qz          (qz),
		.qw          (qw),
		.branch_taken(branch_taken),
		.saturated   (saturated)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (q_count < CW'(QDEPTH)))
		else $error("queue overflow");

	a_trace_w_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && branch_taken == BR_TRACE) |-> !qw[15])
		else $error("negative w on trace branch");

	a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> push.valid)
		else $error("accepted transaction lost in front end");

endmodule
